// ----- src/gdbo_pkg.sv -----
// ----------------------------------------------------------------------------
// gdbo_pkg
// Shared types and constants for the graph walk block.
// ----------------------------------------------------------------------------
package gdbo_pkg;

	localparam int NODE_W = 7;

	// Command codes
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DFS   = 2'd1,
		OP_BFS   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Walk sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_PICK,
		ST_POP,
		ST_DEQ,
		ST_DEQW,
		ST_DONE
	} state_t;

	// Commands from the sequencer to the edge store
	typedef struct packed {
		logic              add;
		logic              clear;
		logic              scan;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
	} edge_cmd_t;

endpackage

// ----- src/graph_dfs_bfs_order.sv -----
// ----------------------------------------------------------------------------
// graph_dfs_bfs_order
// Directed graph store with depth-first and breadth-first walks from node 1.
//
//   channel  handshake              words
//   input    start, busy            op, src_node, dst_node
//   config   cfg_valid, cfg_ready   cfg_data (node_count)
//   result   res_strobe             node, walk, last, overflow
//
// Add and clear are taken while idle and leave the sequencer idle. A walk
// scans the whole edge store once per node step of load, scan and pick. A
// depth-first walk does one such step per visited node plus one per stack
// pop, each pop adding a pop state; a breadth-first walk one per dequeued
// node, each after the two dequeue states, and its pick state enqueues the
// new successors one at a time. The edge memory scan dominates the walk.
// Reset clears counts and flags; the memories need no clearing. Results
// cannot be held off by the receiver.
module graph_dfs_bfs_order import gdbo_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [NODE_W-1:0] src_node,
	input  logic [NODE_W-1:0] dst_node,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [NODE_W-1:0] cfg_data,
	output logic              res_strobe,
	output logic [NODE_W-1:0] node,
	output logic              walk,
	output logic              last,
	output logic              overflow
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int PW = $clog2(MAX_NODES + 1);

	state_t               state_q, state_d;
	edge_cmd_t            cmd;
	logic [NODE_W-1:0]    ncount_q;
	logic [NODE_W-1:0]    n_eff;
	logic [NODE_W-1:0]    cur_q;
	logic [MAX_NODES-1:0] adj;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] avail;
	logic                 scan_done;
	logic                 ovf;
	logic                 bfs_q;
	logic [PW-1:0]        sp_q;
	logic [PW-1:0]        head_q;
	logic [PW-1:0]        tail_q;
	logic [NODE_W-1:0]    wmem [MAX_NODES];
	logic [NODE_W-1:0]    wrdata_s1;
	logic [NW-1:0]        wraddr;
	logic                 wwe;
	logic [NW-1:0]        wwaddr;
	logic [NODE_W-1:0]    wwdata;
	logic [NW-1:0]        low_idx;
	logic [NODE_W-1:0]    nx;
	logic [NODE_W-1:0]    pend_q;
	logic                 emit_q;
	logic [NODE_W-1:0]    enode_q;
	logic                 elast_q;
	logic                 accept;

	assign accept = start && !busy;

	// Effective node count: zero counts as one, saturate at the node limit
	always_comb begin
		if (ncount_q == '0) begin
			n_eff = NODE_W'(1);
		end else if (ncount_q > NODE_W'(MAX_NODES)) begin
			n_eff = NODE_W'(MAX_NODES);
		end else begin
			n_eff = ncount_q;
		end
	end

	// Pick the lowest unvisited successor
	assign avail = adj & ~visited_q;
	always_comb begin
		low_idx = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (avail[i]) begin
				low_idx = NW'(i);
			end
		end
	end
	assign nx = NODE_W'(low_idx) + 1'b1;

	gdbo_edges #(
		.MAX_NODES(MAX_NODES),
		.MAX_EDGES(MAX_EDGES)
	) u_edges (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.n_eff    (n_eff),
		.cur      (cur_q),
		.adj      (adj),
		.scan_done(scan_done),
		.overflow (ovf)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_DFS || op == OP_BFS)) begin
					state_d = (op == OP_DFS) ? ST_LOAD : ST_DEQ;
				end
			end
			ST_LOAD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (bfs_q) begin
					if (avail == '0) begin
						state_d = (head_q == tail_q) ? ST_DONE : ST_DEQ;
					end
				end else if (avail != '0) begin
					state_d = ST_LOAD;
				end else begin
					state_d = (sp_q == PW'(1)) ? ST_DONE : ST_POP;
				end
			end
			ST_POP:  state_d = ST_LOAD;
			ST_DEQ:  state_d = ST_DEQW;
			ST_DEQW: state_d = ST_LOAD;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		busy      = (state_q != ST_IDLE);
		cfg_ready = (state_q == ST_IDLE);
		cmd.add   = accept && (op == OP_ADD);
		cmd.clear = accept && (op == OP_CLEAR);
		cmd.scan  = (state_q == ST_LOAD);
		cmd.src   = src_node;
		cmd.dst   = dst_node;
	end

	// Walk memory write select
	always_comb begin
		wwe    = 1'b0;
		wwaddr = '0;
		wwdata = nx;
		wraddr = NW'(head_q);
		case (state_q)
			ST_IDLE: begin
				wwe    = accept && (op == OP_DFS || op == OP_BFS);
				wwdata = NODE_W'(1);
			end
			ST_PICK: begin
				wwe    = (avail != '0);
				wwaddr = bfs_q ? NW'(tail_q) : NW'(sp_q);
			end
			default: ;
		endcase
		if (state_q == ST_PICK && !bfs_q) begin
			wraddr = NW'(sp_q - PW'(2));
		end
	end

	// Stack and queue memory
	always_ff @(posedge clk) begin
		if (wwe) begin
			wmem[wwaddr] <= wwdata;
		end
		wrdata_s1 <= wmem[wraddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold node count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q <= NODE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			ncount_q <= cfg_data;
		end
	end

	// Walk datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			sp_q      <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			bfs_q     <= 1'b0;
			cur_q     <= NODE_W'(1);
			pend_q    <= NODE_W'(1);
			emit_q    <= 1'b0;
			enode_q   <= '0;
			elast_q   <= 1'b0;
		end else begin
			emit_q  <= (state_q == ST_PICK && !bfs_q && avail != '0) ||
			           (state_q == ST_DEQW && head_q != PW'(1)) ||
			           (state_q == ST_DONE);
			elast_q <= (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (accept && (op == OP_DFS || op == OP_BFS)) begin
						visited_q <= MAX_NODES'(1);
						bfs_q     <= (op == OP_BFS);
						cur_q     <= NODE_W'(1);
						pend_q    <= NODE_W'(1);
						sp_q      <= PW'(1);
						head_q    <= '0;
						tail_q    <= PW'(1);
					end
				end
				ST_PICK: begin
					if (avail != '0) begin
						visited_q[low_idx] <= 1'b1;
						if (bfs_q) begin
							tail_q <= tail_q + 1'b1;
						end else begin
							enode_q <= pend_q;
							pend_q  <= nx;
							cur_q   <= nx;
							sp_q    <= sp_q + 1'b1;
						end
					end else if (!bfs_q) begin
						sp_q <= sp_q - 1'b1;
					end
				end
				ST_POP: cur_q <= wrdata_s1;
				ST_DEQ: head_q <= head_q + 1'b1;
				ST_DEQW: begin
					cur_q <= wrdata_s1;
					if (head_q != PW'(1)) begin
						enode_q <= pend_q;
					end
					pend_q <= wrdata_s1;
				end
				ST_DONE: begin
					enode_q <= pend_q;
				end
				default: ;
			endcase
		end
	end

	assign res_strobe = emit_q;
	assign node       = enode_q;
	assign walk       = bfs_q;
	assign last       = elast_q;
	assign overflow   = ovf;

endmodule

// ----- src/gdbo_edges.sv -----
// ----------------------------------------------------------------------------
// gdbo_edges
// Edge store with fill count and overflow flag. A scan reads every stored
// edge, one a cycle, and collects the successors of one node as a mask.
// ----------------------------------------------------------------------------
module gdbo_edges import gdbo_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  edge_cmd_t            cmd,
	input  logic [NODE_W-1:0]    n_eff,
	input  logic [NODE_W-1:0]    cur,
	output logic [MAX_NODES-1:0] adj,
	output logic                 scan_done,
	output logic                 overflow
);

	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int NW = $clog2(MAX_NODES);

	logic [2*NODE_W-1:0] mem [MAX_EDGES];
	logic [2*NODE_W-1:0] rdata_s1;
	logic                rv_s1;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic                active_q;
	logic                done_q;
	logic                ovf_q;
	logic [MAX_NODES-1:0] adj_q;
	logic                add_ok;
	logic [NODE_W-1:0]   rs;
	logic [NODE_W-1:0]   rd;

	assign add_ok = (cmd.src != '0) && (cmd.src <= n_eff) &&
	                (cmd.dst != '0) && (cmd.dst <= n_eff);
	assign rs = rdata_s1[2*NODE_W-1:NODE_W];
	assign rd = rdata_s1[NODE_W-1:0];

	// Write stored edges
	always_ff @(posedge clk) begin
		if (cmd.add && add_ok && count_q < CW'(MAX_EDGES)) begin
			mem[count_q[AW-1:0]] <= {cmd.src, cmd.dst};
		end
	end

	// Read one edge a cycle during a scan
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[idx_q[AW-1:0]];
	end

	// Track fill count and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.add && add_ok) begin
			if (count_q < CW'(MAX_EDGES)) begin
				count_q <= count_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Advance the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			active_q <= 1'b0;
			rv_s1    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= !cmd.scan && active_q && (idx_q >= count_q) && !rv_s1;
			if (cmd.scan) begin
				idx_q    <= '0;
				active_q <= 1'b1;
				rv_s1    <= 1'b0;
			end else if (active_q) begin
				if (idx_q < count_q) begin
					idx_q <= idx_q + 1'b1;
					rv_s1 <= 1'b1;
				end else begin
					rv_s1 <= 1'b0;
					if (!rv_s1) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	// Collect successors of the current node
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			adj_q <= '0;
		end else if (rv_s1 && rs == cur && rs <= n_eff && rd != '0 && rd <= n_eff) begin
			adj_q[NW'(rd - 1'b1)] <= 1'b1;
		end
	end

	assign adj       = adj_q;
	assign scan_done = done_q;
	assign overflow  = ovf_q;

endmodule
